// ===== design/tsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types, codes and constants of the tar stream deframer.
// ----------------------------------------------------------------------------
package tsd_pkg;

    localparam int SIZE_BITS_DEF = 36;

    // header layout, byte offsets within a 512-byte block
    localparam logic [8:0] BLOCK_LAST = 9'd511;
    localparam logic [8:0] SIZE_AT    = 9'd124;
    localparam logic [8:0] SIZE_END   = 9'd135;
    localparam logic [8:0] TYPE_AT    = 9'd156;
    localparam logic [8:0] MAGIC_AT   = 9'd257;
    localparam logic [8:0] MAGIC_END  = 9'd261;

    // typeflag characters
    localparam logic [7:0] TF_NUL  = 8'h00;
    localparam logic [7:0] TF_REG  = 8'h30; // '0'
    localparam logic [7:0] TF_LINK = 8'h31; // '1'
    localparam logic [7:0] TF_SYM  = 8'h32; // '2'
    localparam logic [7:0] TF_DIR  = 8'h35; // '5'
    localparam logic [7:0] TF_PAXG = 8'h67; // 'g'
    localparam logic [7:0] TF_PAXX = 8'h78; // 'x'

    typedef enum logic [2:0] {
        EV_DATA    = 3'd0,
        EV_FILE    = 3'd1,
        EV_DIR     = 3'd2,
        EV_LINK    = 3'd3,
        EV_PAX     = 3'd4,
        EV_BAD_MAG = 3'd5,
        EV_BAD_TYP = 3'd6,
        EV_END     = 3'd7
    } t_event;

    // control from the header walker to the size field parser
    typedef struct packed {
        logic load;   // size field byte present
        logic clear;  // header complete, restart the parser
    } t_acc_ctl;

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h75; // u
            3'd1:    c = 8'h73; // s
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h61; // a
            3'd4:    c = 8'h72; // r
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== design/tsd_octal_acc.sv =====
// ----------------------------------------------------------------------------
// tsd_octal_acc
// Octal size field parser: skips leading white space, accumulates octal
// digits, stops at the first other byte, saturates at the field maximum.
// ----------------------------------------------------------------------------
module tsd_octal_acc
    import tsd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_acc_ctl             i_ctl,
    input  logic [7:0]           i_byte,
    output logic [SIZE_BITS-1:0] o_size
);

    typedef enum logic [2:0] {
        DP_SKIP   = 3'b001,
        DP_DIGITS = 3'b010,
        DP_DONE   = 3'b100
    } t_dphase;

    t_dphase              r_dphase, n_dphase;
    logic [SIZE_BITS-1:0] r_acc, n_acc;
    logic                 is_digit;
    logic                 is_space;
    logic                 ovf;

    assign is_digit = (i_byte >= 8'h30) && (i_byte <= 8'h37);
    assign is_space = (i_byte == 8'h20) || ((i_byte >= 8'h09) && (i_byte <= 8'h0d));
    // shifting by three overflows exactly when any of the top three bits is set
    assign ovf      = (r_acc[SIZE_BITS-1 -: 3] != 3'd0);

    always_comb begin
        n_dphase = r_dphase;
        n_acc    = r_acc;
        if (i_ctl.clear) begin
            n_dphase = DP_SKIP;
            n_acc    = '0;
        end else if (i_ctl.load) begin
            unique case (r_dphase)
                DP_SKIP: begin
                    if (is_digit) begin
                        n_acc    = SIZE_BITS'(i_byte[2:0]);
                        n_dphase = DP_DIGITS;
                    end else if (!is_space) begin
                        n_dphase = DP_DONE;
                    end
                end
                DP_DIGITS: begin
                    if (is_digit) begin
                        n_acc = ovf ? '1 : {r_acc[SIZE_BITS-4:0], i_byte[2:0]};
                    end else begin
                        n_dphase = DP_DONE;
                    end
                end
                DP_DONE: ;
                default: n_dphase = DP_DONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dphase <= DP_SKIP;
            r_acc    <= '0;
        end else begin
            r_dphase <= n_dphase;
            r_acc    <= n_acc;
        end
    end

    assign o_size = r_acc;

endmodule

// ===== design/tar_stream_deframer.sv =====
// ----------------------------------------------------------------------------
// tar_stream_deframer
// Splits an uncompressed ustar byte stream into entry events and file bytes.
// ----------------------------------------------------------------------------
// Slave side takes one archive byte per transfer. Master side gives at most
// one result per byte: an entry event after the last byte of each 512-byte
// header, or a content byte of a regular file, with tlast on the final one.
// Header bytes, link and directory sizes, PAX bodies and block padding give
// nothing. Two zero headers in a row give the end event; bad magic or an
// unsupported typeflag gives an error event. After either, bytes are taken
// and dropped until reset.
// A byte goes from the slave side into the input register, then through the
// parse logic into the output register on the master side.
// One byte per cycle is sustained; the input register drains whenever the
// output register is empty or being read, so a stalled receiver holds the
// result and backs up the slave side after one more byte.
// Synchronous reset returns the parser to the start of a header with empty
// registers on both sides.
// ----------------------------------------------------------------------------
module tar_stream_deframer
    import tsd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    localparam int TDATA_W  = ((19 + SIZE_BITS + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,  // [7:0] stream_byte
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // [2:0] event_res, [10:3] payload_byte, [SIZE_BITS+10:11] entry_size,
    // [SIZE_BITS+18:SIZE_BITS+11] entry_type, rest zero
    output logic [TDATA_W-1:0] o_m_axis_tdata,
    output logic               o_m_axis_tlast   // last_of_file
);

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_FILE   = 6'b000010,
        PH_PAX    = 6'b000100,
        PH_PAD    = 6'b001000,
        PH_END    = 6'b010000,
        PH_ERROR  = 6'b100000
    } t_phase;

    // input register
    logic                 r_in_vld;
    logic [7:0]           r_in_byte;
    logic                 proc;

    // parse state
    t_phase               r_phase, n_phase;
    logic [8:0]           r_off, n_off;
    logic [SIZE_BITS-1:0] r_bl, n_bl;
    logic [8:0]           r_pad, n_pad;
    logic                 r_prefix_zero, n_prefix_zero;
    logic                 r_magic_ok, n_magic_ok;
    logic [7:0]           r_type, n_type;
    logic                 r_seen_zero, n_seen_zero;

    t_acc_ctl             acc_ctl;
    logic [SIZE_BITS-1:0] acc_size;

    // result
    logic                 res_vld;
    t_event               res_ev;
    logic [7:0]           res_pay;
    logic [SIZE_BITS-1:0] res_size;
    logic [7:0]           res_type;
    logic                 res_last;

    // output register
    logic                 r_m_vld;
    t_event               r_ev;
    logic [7:0]           r_pay;
    logic [SIZE_BITS-1:0] r_size;
    logic [7:0]           r_otype;
    logic                 r_last;

    logic [SIZE_BITS-1:0] bl_dec;
    logic [8:0]           pad_dec;
    logic [8:0]           body_pad;
    logic                 in_magic;

    assign proc            = r_in_vld && (!r_m_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || proc;

    assign bl_dec   = (r_bl == '0) ? '0 : r_bl - 1'b1;
    assign pad_dec  = (r_pad == '0) ? '0 : r_pad - 1'b1;
    assign body_pad = 9'd0 - acc_size[8:0];
    assign in_magic = (r_off >= MAGIC_AT) && (r_off <= MAGIC_END);

    tsd_octal_acc #(
        .SIZE_BITS (SIZE_BITS)
    ) u_octal_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (acc_ctl),
        .i_byte  (r_in_byte),
        .o_size  (acc_size)
    );

    always_comb begin
        n_phase       = r_phase;
        n_off         = r_off;
        n_bl          = r_bl;
        n_pad         = r_pad;
        n_prefix_zero = r_prefix_zero;
        n_magic_ok    = r_magic_ok;
        n_type        = r_type;
        n_seen_zero   = r_seen_zero;
        acc_ctl       = '0;
        res_vld       = 1'b0;
        res_ev        = EV_DATA;
        res_pay       = '0;
        res_size      = '0;
        res_type      = '0;
        res_last      = 1'b0;

        if (proc) begin
            unique case (r_phase)
                PH_FILE: begin
                    n_bl    = bl_dec;
                    res_vld = 1'b1;
                    res_pay = r_in_byte;
                    if (bl_dec == '0) begin
                        res_last = 1'b1;
                        n_phase  = (r_pad != '0) ? PH_PAD : PH_HEADER;
                    end
                end
                PH_PAX: begin
                    n_bl = bl_dec;
                    if (bl_dec == '0) begin
                        n_phase = (r_pad != '0) ? PH_PAD : PH_HEADER;
                    end
                end
                PH_PAD: begin
                    n_pad = pad_dec;
                    if (pad_dec == '0) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if (r_off < MAGIC_AT && r_in_byte != 8'h00) begin
                        n_prefix_zero = 1'b0;
                    end
                    if (r_off == TYPE_AT) begin
                        n_type = r_in_byte;
                    end
                    if (in_magic && r_in_byte != magic_char(3'(r_off - MAGIC_AT))) begin
                        n_magic_ok = 1'b0;
                    end
                    acc_ctl.load = (r_off >= SIZE_AT) && (r_off <= SIZE_END);

                    if (r_off == BLOCK_LAST) begin
                        // header complete: restart the collectors and dispatch
                        n_off         = '0;
                        n_prefix_zero = 1'b1;
                        n_magic_ok    = 1'b1;
                        n_type        = '0;
                        acc_ctl.clear = 1'b1;
                        res_type      = r_type;
                        if (r_prefix_zero) begin
                            if (r_seen_zero) begin
                                n_phase = PH_END;
                                res_vld = 1'b1;
                                res_ev  = EV_END;
                            end else begin
                                n_seen_zero = 1'b1;
                            end
                        end else begin
                            n_seen_zero = 1'b0;
                            res_vld     = 1'b1;
                            res_size    = acc_size;
                            priority if (!r_magic_ok) begin
                                n_phase = PH_ERROR;
                                res_ev  = EV_BAD_MAG;
                            end else if (r_type == TF_DIR) begin
                                res_ev = EV_DIR;
                            end else if (r_type == TF_REG || r_type == TF_NUL
                                         || r_type == TF_PAXG || r_type == TF_PAXX) begin
                                res_ev  = (r_type == TF_REG || r_type == TF_NUL)
                                          ? EV_FILE : EV_PAX;
                                n_bl    = acc_size;
                                n_pad   = body_pad;
                                if (acc_size != '0) begin
                                    n_phase = (res_ev == EV_FILE) ? PH_FILE : PH_PAX;
                                end
                            end else if (r_type == TF_LINK || r_type == TF_SYM) begin
                                res_ev = EV_LINK;
                            end else begin
                                n_phase = PH_ERROR;
                                res_ev  = EV_BAD_TYP;
                            end
                        end
                    end else begin
                        n_off = r_off + 1'b1;
                    end
                end
                PH_END, PH_ERROR: ;
                default: n_phase = PH_ERROR;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_m_vld       <= 1'b0;
            r_phase       <= PH_HEADER;
            r_off         <= '0;
            r_bl          <= '0;
            r_pad         <= '0;
            r_prefix_zero <= 1'b1;
            r_magic_ok    <= 1'b1;
            r_type        <= '0;
            r_seen_zero   <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                r_in_vld <= 1'b1;
            end else if (proc) begin
                r_in_vld <= 1'b0;
            end
            if (proc && res_vld) begin
                r_m_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_vld <= 1'b0;
            end
            r_phase       <= n_phase;
            r_off         <= n_off;
            r_bl          <= n_bl;
            r_pad         <= n_pad;
            r_prefix_zero <= n_prefix_zero;
            r_magic_ok    <= n_magic_ok;
            r_type        <= n_type;
            r_seen_zero   <= n_seen_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (proc && res_vld) begin
            r_ev    <= res_ev;
            r_pay   <= res_pay;
            r_size  <= res_size;
            r_otype <= res_type;
            r_last  <= res_last;
        end
    end

    always_comb begin
        o_m_axis_tdata                             = '0;
        o_m_axis_tdata[2:0]                        = r_ev;
        o_m_axis_tdata[10:3]                       = r_pay;
        o_m_axis_tdata[SIZE_BITS+10:11]            = r_size;
        o_m_axis_tdata[SIZE_BITS+18:SIZE_BITS+11]  = r_otype;
    end

    assign o_m_axis_tvalid = r_m_vld;
    assign o_m_axis_tlast  = r_last;

endmodule

// ===== dv/tar_deframe_checker.sv =====
// ----------------------------------------------------------------------------
// tar_deframe_checker
// Passive checker for the tar stream deframer: follows every byte transfer
// through its own ustar walker, queues the entry events and content bytes
// that each byte should give, and compares every result transfer with the
// oldest one waiting.
// ----------------------------------------------------------------------------
module tar_deframe_checker
    import tsd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    parameter int TDATA_W   = ((19 + SIZE_BITS + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [7:0]         i_s_tdata,   // [7:0] stream_byte
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    // [2:0] event_res, [10:3] payload_byte, [SIZE_BITS+10:11] entry_size,
    // [SIZE_BITS+18:SIZE_BITS+11] entry_type
    input  logic [TDATA_W-1:0] i_m_tdata,
    input  logic               i_m_tlast,   // last_of_file
    output int                 o_mismatches,
    output int                 o_pending
);

    typedef enum logic [2:0] {
        PP_HEADER, PP_FILE, PP_PAX, PP_PAD, PP_END, PP_ERROR
    } parse_phase_t;

    typedef enum logic [1:0] {SZ_SKIP, SZ_DIGITS, SZ_DONE} size_scan_t;

    typedef struct packed {
        t_event                ev;
        logic [7:0]            payload;
        logic [SIZE_BITS-1:0]  size;
        logic [7:0]            etype;
        logic                  last;
    } tar_record_t;

    localparam logic [SIZE_BITS-1:0] SIZE_MAX   = '1;
    localparam logic [39:0]          MAGIC_TEXT = "ustar";

    parse_phase_t          phase;
    logic [8:0]            hdr_off;
    logic [SIZE_BITS-1:0]  body_left;
    logic [8:0]            pad_left;
    logic [SIZE_BITS-1:0]  size_acc;
    size_scan_t            size_scan;
    logic                  prefix_zero;
    logic                  magic_ok;
    logic [7:0]            type_byte;
    logic                  seen_zero;
    int                    mismatch_cnt;

    tar_record_t tar_events_due[$];

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
    endfunction

    function automatic logic is_octal(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h37);
    endfunction

    task automatic clear_header();
        hdr_off     = '0;
        size_acc    = '0;
        size_scan   = SZ_SKIP;
        prefix_zero = 1'b1;
        magic_ok    = 1'b1;
        type_byte   = '0;
    endtask

    // strtol-like: skip white space, take octal digits, stop at anything else
    task automatic scan_size_byte(input logic [7:0] b);
        logic [63:0] acc;
        logic [63:0] dig;
        dig = {56'd0, b} - 64'h30;
        acc = 64'(size_acc);
        case (size_scan)
            SZ_SKIP: begin
                if (!is_space(b)) begin
                    if (is_octal(b)) begin
                        size_acc  = SIZE_BITS'(dig);
                        size_scan = SZ_DIGITS;
                    end else begin
                        size_scan = SZ_DONE;
                    end
                end
            end
            SZ_DIGITS: begin
                if (!is_octal(b))
                    size_scan = SZ_DONE;
                else if (acc > (64'(SIZE_MAX) >> 3) || (acc << 3) + dig > 64'(SIZE_MAX))
                    size_acc = SIZE_MAX;
                else
                    size_acc = SIZE_BITS'((acc << 3) + dig);
            end
            default: ;
        endcase
    endtask

    task automatic start_body(input parse_phase_t body, input logic [SIZE_BITS-1:0] sz);
        body_left = sz;
        pad_left  = 9'd0 - sz[8:0];
        phase     = (sz == '0) ? PP_HEADER : body;
    endtask

    task automatic parse_tar_byte(input logic [7:0] b);
        tar_record_t          rec;
        logic [8:0]           off;
        int                   mk;
        logic [SIZE_BITS-1:0] sz;
        logic [7:0]           tf;
        logic                 was_zero;
        logic                 magic_good;
        rec = '0;
        off = hdr_off;
        case (phase)
            PP_FILE: begin
                rec.ev      = EV_DATA;
                rec.payload = b;
                if (body_left != '0)
                    body_left--;
                if (body_left == '0) begin
                    rec.last = 1'b1;
                    phase    = (pad_left != '0) ? PP_PAD : PP_HEADER;
                end
                tar_events_due.push_back(rec);
            end
            PP_PAX: begin
                if (body_left != '0)
                    body_left--;
                if (body_left == '0)
                    phase = (pad_left != '0) ? PP_PAD : PP_HEADER;
            end
            PP_PAD: begin
                if (pad_left != '0)
                    pad_left--;
                if (pad_left == '0)
                    phase = PP_HEADER;
            end
            PP_HEADER: begin
                if (off < MAGIC_AT && b != 8'h00)
                    prefix_zero = 1'b0;
                if (off >= SIZE_AT && off <= SIZE_END)
                    scan_size_byte(b);
                if (off == TYPE_AT)
                    type_byte = b;
                if (off >= MAGIC_AT && off <= MAGIC_END) begin
                    mk = int'(MAGIC_END) - int'(off);
                    if (b != MAGIC_TEXT[8*mk +: 8])
                        magic_ok = 1'b0;
                end
                if (off != BLOCK_LAST) begin
                    hdr_off = off + 9'd1;
                end else begin
                    sz         = size_acc;
                    tf         = type_byte;
                    was_zero   = prefix_zero;
                    magic_good = magic_ok;
                    clear_header();
                    if (was_zero) begin
                        // first zero block is silent, the second one ends the archive
                        if (seen_zero) begin
                            phase     = PP_END;
                            rec.ev    = EV_END;
                            rec.etype = tf;
                            tar_events_due.push_back(rec);
                        end
                        seen_zero = 1'b1;
                    end else begin
                        seen_zero = 1'b0;
                        rec.size  = sz;
                        rec.etype = tf;
                        if (!magic_good) begin
                            phase  = PP_ERROR;
                            rec.ev = EV_BAD_MAG;
                        end else if (tf == TF_DIR) begin
                            rec.ev = EV_DIR;
                        end else if (tf == TF_REG || tf == TF_NUL) begin
                            start_body(PP_FILE, sz);
                            rec.ev = EV_FILE;
                        end else if (tf == TF_PAXG || tf == TF_PAXX) begin
                            start_body(PP_PAX, sz);
                            rec.ev = EV_PAX;
                        end else if (tf == TF_LINK || tf == TF_SYM) begin
                            rec.ev = EV_LINK;
                        end else begin
                            phase  = PP_ERROR;
                            rec.ev = EV_BAD_TYP;
                        end
                        tar_events_due.push_back(rec);
                    end
                end
            end
            default: ;  // ended or in error: bytes are dropped
        endcase
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        tar_record_t want;
        tar_record_t got;
        if (!i_rst_n) begin
            phase        = PP_HEADER;
            body_left    = '0;
            pad_left     = '0;
            seen_zero    = 1'b0;
            mismatch_cnt = 0;
            clear_header();
            tar_events_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.ev      = t_event'(i_m_tdata[2:0]);
                got.payload = i_m_tdata[10:3];
                got.size    = i_m_tdata[SIZE_BITS+10:11];
                got.etype   = i_m_tdata[SIZE_BITS+18:SIZE_BITS+11];
                got.last    = i_m_tlast;
                if (tar_events_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual event %0d",
                             $time, got.ev);
                    mismatch_cnt++;
                end else begin
                    want = tar_events_due.pop_front();
                    check_field("event_res", 64'(want.ev), 64'(got.ev));
                    check_field("payload_byte", 64'(want.payload), 64'(got.payload));
                    check_field("entry_size", 64'(want.size), 64'(got.size));
                    check_field("entry_type", 64'(want.etype), 64'(got.etype));
                    check_field("last_of_file", 64'(want.last), 64'(got.last));
                end
            end
            // a byte's result cannot leave in the cycle it is taken
            if (i_s_tvalid && i_s_tready)
                parse_tar_byte(i_s_tdata);
        end
        o_pending    <= tar_events_due.size();
        o_mismatches <= mismatch_cnt;
    end

endmodule

// ===== dv/tb_tar_stream_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_tar_stream_deframer
// Feeds the deframer a short generated ustar archive: a regular file whose
// body carries the receiver hold-off, a drain, then a random close: two zero
// blocks, bad magic, or a lone zero block or bodiless entry followed by an
// unsupported typeflag, and trailing bytes that must be dropped. Both stream
// sides idle at random; the checker instance predicts and compares.
// ----------------------------------------------------------------------------
module tb_tar_stream_deframer;
    import tsd_pkg::*;

    localparam int SIZE_BITS      = SIZE_BITS_DEF;
    localparam int TDATA_W        = ((19 + SIZE_BITS + 7) / 8) * 8;
    localparam int IDLE_LIMIT     = 5000;
    localparam int HOLD_OFF       = 400;
    localparam int HOLD_AT_RESULT = 30;
    localparam int FIRST_MIN      = 64;
    localparam int TAIL_BYTES     = 128;
    localparam int SETTLE_CYCLES  = 10;

    typedef enum {FMT_FREE, FMT_FULL, FMT_BLANK, FMT_JUNK} size_fmt_t;
    typedef enum {CLOSE_END, CLOSE_BAD_MAGIC, CLOSE_BAD_TYPE} archive_close_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;

    int             mismatches;
    int             pending;
    int             idle_cycles;
    int             results_seen;
    int             entries_sent;
    bit             steady;
    logic [7:0]     hdr_bytes [512];

    tar_stream_deframer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    tar_deframe_checker #(
        .SIZE_BITS (SIZE_BITS),
        .TDATA_W   (TDATA_W)
    ) deframe_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [7:0] space_char();
        case ($urandom_range(0, 5))
            0:       return 8'h09;
            1:       return 8'h0a;
            2:       return 8'h0b;
            3:       return 8'h0c;
            4:       return 8'h0d;
            default: return 8'h20;
        endcase
    endfunction

    function automatic logic [7:0] octal_char(input logic [35:0] v, input int pos);
        return 8'h30 + 8'((v >> (3 * pos)) & 36'd7);
    endfunction

    // byte that ends a run of digits
    function automatic logic [7:0] stop_char();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = 8'h00;
            1: c = 8'h20;
            default: begin
                do c = 8'($urandom); while (c >= 8'h30 && c <= 8'h37);
            end
        endcase
        return c;
    endfunction

    // first non-blank byte that is no digit, e.g. a sign
    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = 8'h2b;
            1: c = 8'h2d;
            2: c = 8'h00;
            default: begin
                do c = 8'($urandom);
                while ((c >= 8'h30 && c <= 8'h37) || c == 8'h20 || (c >= 8'h09 && c <= 8'h0d));
            end
        endcase
        return c;
    endfunction

    function automatic logic is_known_type(input logic [7:0] t);
        return t == TF_NUL || t == TF_REG || t == TF_LINK || t == TF_SYM ||
               t == TF_DIR || t == TF_PAXG || t == TF_PAXX;
    endfunction

    function automatic logic [35:0] file_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 36'd0;
        else if (r < 55)
            return 36'($urandom_range(1, 20));
        else if (r < 85)
            return 36'($urandom_range(21, 600));
        else if (r < 95)
            return 36'(512 * $urandom_range(1, 2));
        return 36'($urandom_range(601, 2000));
    endfunction

    // sizes of bodiless entries may be anything up to the full field
    function automatic logic [35:0] wide_size();
        logic [63:0] r;
        r = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0)
            return 36'd0;
        return r[35:0] >> $urandom_range(0, 35);
    endfunction

    function automatic size_fmt_t pick_fmt();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return FMT_FREE;
        else if (r < 82)
            return FMT_FULL;
        else if (r < 91)
            return FMT_BLANK;
        return FMT_JUNK;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // leading 257 bytes zero; the rest of the block does not matter
    task automatic send_zero_block();
        for (int i = 0; i < 512; i++)
            send_byte((i < int'(MAGIC_AT)) ? 8'h00 : 8'($urandom));
    endtask

    task automatic send_entry(input logic [7:0] tflag, input logic [35:0] size,
                              input size_fmt_t fmt, input bit magic_good);
        int          lead;
        int          digits;
        int          ndig;
        int          fld;
        logic [35:0] v;
        bit          has_body;
        longint      pad;
        logic [7:0]  b;
        fld = int'(SIZE_AT);
        for (int i = 0; i < 512; i++)
            hdr_bytes[i] = 8'($urandom);
        hdr_bytes[TYPE_AT] = tflag;
        hdr_bytes[257] = 8'h75;
        hdr_bytes[258] = 8'h73;
        hdr_bytes[259] = 8'h74;
        hdr_bytes[260] = 8'h61;
        hdr_bytes[261] = 8'h72;
        if (!magic_good)
            hdr_bytes[int'(MAGIC_AT) + $urandom_range(0, 4)] ^= 8'($urandom_range(1, 255));
        case (fmt)
            FMT_FULL: begin
                for (int k = 0; k < 12; k++)
                    hdr_bytes[fld + k] = octal_char(size, 11 - k);
            end
            FMT_BLANK: begin
                for (int k = 0; k < 12; k++)
                    hdr_bytes[fld + k] = space_char();
            end
            FMT_JUNK: begin
                lead = $urandom_range(0, 3);
                for (int k = 0; k < lead; k++)
                    hdr_bytes[fld + k] = space_char();
                hdr_bytes[fld + lead] = junk_char();
            end
            default: begin
                ndig = 1;
                v    = size >> 3;
                while (v != '0) begin
                    ndig++;
                    v = v >> 3;
                end
                lead   = $urandom_range(0, 12 - ndig);
                digits = $urandom_range(ndig, 12 - lead);
                for (int k = 0; k < lead; k++)
                    hdr_bytes[fld + k] = space_char();
                for (int k = 0; k < digits; k++)
                    hdr_bytes[fld + lead + k] = octal_char(size, digits - 1 - k);
                if (lead + digits < 12)
                    hdr_bytes[fld + lead + digits] = stop_char();
            end
        endcase
        for (int i = 0; i < 512; i++)
            send_byte(hdr_bytes[i]);

        has_body = magic_good && (tflag == TF_REG || tflag == TF_NUL ||
                                  tflag == TF_PAXG || tflag == TF_PAXX);
        if (has_body && size != '0) begin
            for (longint i = 0; i < longint'(size); i++) begin
                b = 8'($urandom);
                if (entries_sent == 0 && i < 2)
                    b = (i == 0) ? 8'h00 : 8'hff;
                send_byte(b);
            end
            pad = longint'(9'd0 - size[8:0]);
            for (longint i = 0; i < pad; i++)
                send_byte(8'($urandom));
        end
        entries_sent++;
    endtask

    // cycles without any transfer on either side
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (m_tvalid && m_tready)
            results_seen <= results_seen + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random ready pattern, one long hold-off early in a file body
    initial begin
        bit held_off;
        int run;
        held_off = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!held_off && results_seen >= HOLD_AT_RESULT) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
            if ($urandom_range(0, 4) != 0) begin
                int gap;
                gap = pick_gap();
                if (gap != 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 24);
            // cut a ready stretch short once the hold-off is due
            for (int i = 0; i < run; i++) begin
                @(posedge clk);
                if (!held_off && results_seen >= HOLD_AT_RESULT)
                    break;
            end
        end
    end

    initial begin
        archive_close_t close_kind;
        logic [7:0]     tflag;
        logic [35:0]    size;
        size_fmt_t      fmt;

        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= 8'h00;
        idle_cycles  <= 0;
        results_seen <= 0;
        entries_sent = 0;
        steady       = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // regular file, body long enough for the receiver hold-off to land in it
        tflag = ($urandom_range(0, 1) == 0) ? TF_REG : TF_NUL;
        size  = 36'($urandom_range(FIRST_MIN, 512));
        fmt   = ($urandom_range(0, 3) == 0) ? FMT_FULL : FMT_FREE;
        send_entry(tflag, size, fmt, 1'b1);

        // let everything drain before the close
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        // only one way to close the archive per run, the block stays put after it
        steady     = ($urandom_range(0, 3) == 0);
        close_kind = archive_close_t'($urandom_range(0, 2));
        case (close_kind)
            CLOSE_END: begin
                send_zero_block();
                send_zero_block();
            end
            CLOSE_BAD_MAGIC: begin
                tflag = ($urandom_range(0, 1) == 0) ? TF_REG : 8'($urandom);
                send_entry(tflag, file_size(), FMT_FREE, 1'b0);
            end
            default: begin
                if ($urandom_range(0, 1) == 0) begin
                    send_zero_block();                   // lone zero block, then carry on
                end else begin
                    fmt = pick_fmt();
                    case ($urandom_range(0, 2))
                        0: begin
                            tflag = TF_DIR;
                            size  = wide_size();
                        end
                        1: begin
                            tflag = ($urandom_range(0, 1) == 0) ? TF_LINK : TF_SYM;
                            size  = wide_size();
                        end
                        default: begin
                            tflag = ($urandom_range(0, 1) == 0) ? TF_PAXG : TF_PAXX;
                            size  = '0;
                        end
                    endcase
                    if (fmt == FMT_BLANK || fmt == FMT_JUNK)
                        size = '0;
                    send_entry(tflag, size, fmt, 1'b1);
                end
                do tflag = 8'($urandom); while (is_known_type(tflag));
                send_entry(tflag, wide_size(), FMT_FREE, 1'b1);
            end
        endcase
        steady = 1'b0;
        for (int i = 0; i < TAIL_BYTES; i++)
            send_byte(8'($urandom));

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tsd_pkg.sv
design/tsd_octal_acc.sv
design/tar_stream_deframer.sv
dv/tar_deframe_checker.sv
dv/tb_tar_stream_deframer.sv
